@@ hw/rtl/lcwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lcwd_pkg: shared types and constants of the LCW decompressor
// Parse phases, error codes, opcode values and the pipeline stage word.
// ----------------------------------------------------------------------------
`default_nettype none

package lcwd_pkg;

    // parse phase of the compressed stream
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LIT,
        PH_ARG1,
        PH_CNT_HI,
        PH_ARG3,
        PH_POS_HI,
        PH_COPY,
        PH_FILL
    } phase_t;

    // status reported with every result word
    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_CMD,
        ERR_REF,
        ERR_FULL
    } err_t;

    // input word kind
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // opcode values and masks
    localparam logic [7:0] OP_END    = 8'h80;
    localparam logic [7:0] OP_FILL   = 8'hFE;
    localparam logic [7:0] OP_LCOPY  = 8'hFF;
    localparam logic [7:0] MASK_CNT6 = 8'h3F;
    localparam logic [15:0] MIN_COPY = 16'd3;

    // one item between acceptance and the output register
    typedef struct packed {
        logic        wr;        // item writes one history byte
        logic        is_copy;   // byte comes from the history read
        logic [7:0]  data;      // literal or fill byte
        logic [15:0] pos;       // write position
        logic        want;
        logic        done;
        logic [16:0] total;
        err_t        err;
        logic        fwd;       // read hit the byte written in the same cycle
        logic [7:0]  fwd_data;
    } stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/lcwd_ram.sv @@
// ----------------------------------------------------------------------------
// lcwd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lz_copy_fill_decompressor_unit.sv @@
// ----------------------------------------------------------------------------
// lz_copy_fill_decompressor_unit: LCW (Format80) stream decompressor
// Parses compressed bytes into literal, fill, relative and absolute copy commands
// and emits one result word per input word, with literal bytes on data words and
// copy or fill bytes on step requests; the output history is kept in a RAM.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                               | tuser
//  --------+-----+--------------------------------------------------+----------
//  s_      | in  | in_byte                                          | command
//  m_      | out | out_byte, out_position, want_byte, done_res,     | out_valid
//          |     | total_length, error_code, zero pad               |
//
//  one word in and one word out per cycle while m_ does not stall; an accepted
//  word passes the read stage, which reads the history, then the output register
//  a copy byte whose source is written as it is read is forwarded from the write port
//  reset clears the parser; history contents are not cleared
//  a stalled m_ side holds the output register, one more word waits in the
//  read stage, then s_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module lz_copy_fill_decompressor_unit #(
    parameter int OUT_SIZE = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // out_byte, out_position, want_byte, done_res,
                                        // total_length, error_code, pad
    output logic             m_tuser    // out_valid
);

    localparam int ADDR_W = $clog2(OUT_SIZE);
    localparam logic [16:0] OUT_LIMIT = 17'(OUT_SIZE);

    // parser state
    lcwd_pkg::phase_t phase_reg, phase_next;
    logic [16:0] wp_reg, wp_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] cp_reg, cp_next;
    logic [7:0]  fill_reg, fill_next;
    logic [7:0]  op_reg, op_next;
    logic        fin_reg, fin_next;

    // pipeline
    logic             s1_valid_reg;
    lcwd_pkg::stage_t s1_reg, s1_next;
    logic             out_valid_reg;
    logic             out_flag_reg;
    logic [7:0]       out_byte_reg;
    logic [15:0]      out_pos_reg;
    logic             out_want_reg;
    logic             out_done_reg;
    logic [16:0]      out_total_reg;
    lcwd_pkg::err_t   out_err_reg;

    logic        accept;
    logic        s1_adv;
    logic        full;
    logic        copy_bad;
    logic        busy;
    logic [11:0] rel_dist;
    logic        dist_bad;
    logic        item_wr;
    logic        item_copy;
    logic [7:0]  item_data;
    lcwd_pkg::err_t item_err;
    logic [7:0]  ram_q;
    logic [7:0]  s1_wdata;

    // handshakes
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // shared conditions
    assign full     = wp_reg >= OUT_LIMIT;
    assign busy     = phase_reg == lcwd_pkg::PH_COPY || phase_reg == lcwd_pkg::PH_FILL;
    assign copy_bad = phase_reg == lcwd_pkg::PH_COPY && {1'b0, cp_reg} >= wp_reg;
    assign rel_dist = {op_reg[3:0], s_tdata};
    assign dist_bad = {5'd0, rel_dist} > wp_reg;

    // next state of the parser
    always_comb
    begin
        phase_next = phase_reg;
        wp_next    = wp_reg;
        cnt_next   = cnt_reg;
        cp_next    = cp_reg;
        fill_next  = fill_reg;
        op_next    = op_reg;
        fin_next   = fin_reg;
        if (accept && !fin_reg)
        begin
            if (s_tuser == lcwd_pkg::CMD_STEP)
            begin
                if (busy)
                begin
                    if (full || copy_bad)
                    begin
                        cnt_next   = '0;
                        phase_next = lcwd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        if (phase_reg == lcwd_pkg::PH_COPY)
                        begin
                            cp_next = cp_reg + 16'd1;
                        end
                        wp_next  = wp_reg + 17'd1;
                        cnt_next = cnt_reg - 16'd1;
                        if (cnt_reg == 16'd1)
                        begin
                            phase_next = lcwd_pkg::PH_IDLE;
                        end
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    lcwd_pkg::PH_IDLE:
                    begin
                        op_next = s_tdata;
                        if (!s_tdata[7])
                        begin
                            cnt_next   = 16'(s_tdata[7:4]) + lcwd_pkg::MIN_COPY;
                            phase_next = lcwd_pkg::PH_ARG1;
                        end
                        else if (!s_tdata[6])
                        begin
                            if (s_tdata == lcwd_pkg::OP_END)
                            begin
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = 16'(s_tdata & lcwd_pkg::MASK_CNT6);
                                phase_next = lcwd_pkg::PH_LIT;
                            end
                        end
                        else if (s_tdata == lcwd_pkg::OP_FILL || s_tdata == lcwd_pkg::OP_LCOPY)
                        begin
                            cnt_next   = '0;
                            phase_next = lcwd_pkg::PH_ARG1;
                        end
                        else
                        begin
                            cnt_next   = 16'(s_tdata & lcwd_pkg::MASK_CNT6) + lcwd_pkg::MIN_COPY;
                            phase_next = lcwd_pkg::PH_ARG1;
                        end
                    end
                    lcwd_pkg::PH_LIT:
                    begin
                        if (!full)
                        begin
                            wp_next = wp_reg + 17'd1;
                        end
                        cnt_next = cnt_reg - 16'd1;
                        if (cnt_reg == 16'd1)
                        begin
                            phase_next = lcwd_pkg::PH_IDLE;
                        end
                    end
                    lcwd_pkg::PH_ARG1:
                    begin
                        if (!op_reg[7])
                        begin
                            if (dist_bad)
                            begin
                                cnt_next   = '0;
                                phase_next = lcwd_pkg::PH_IDLE;
                            end
                            else
                            begin
                                cp_next    = 16'(wp_reg - {5'd0, rel_dist});
                                phase_next = lcwd_pkg::PH_COPY;
                            end
                        end
                        else if (op_reg == lcwd_pkg::OP_FILL || op_reg == lcwd_pkg::OP_LCOPY)
                        begin
                            cnt_next   = {8'd0, s_tdata};
                            phase_next = lcwd_pkg::PH_CNT_HI;
                        end
                        else
                        begin
                            cp_next    = {8'd0, s_tdata};
                            phase_next = lcwd_pkg::PH_POS_HI;
                        end
                    end
                    lcwd_pkg::PH_CNT_HI:
                    begin
                        cnt_next   = cnt_reg | {s_tdata, 8'd0};
                        phase_next = lcwd_pkg::PH_ARG3;
                    end
                    lcwd_pkg::PH_ARG3:
                    begin
                        if (op_reg == lcwd_pkg::OP_FILL)
                        begin
                            fill_next  = s_tdata;
                            phase_next = (cnt_reg != '0) ? lcwd_pkg::PH_FILL : lcwd_pkg::PH_IDLE;
                        end
                        else
                        begin
                            cp_next    = {8'd0, s_tdata};
                            phase_next = lcwd_pkg::PH_POS_HI;
                        end
                    end
                    lcwd_pkg::PH_POS_HI:
                    begin
                        cp_next    = cp_reg | {s_tdata, 8'd0};
                        phase_next = (cnt_reg != '0) ? lcwd_pkg::PH_COPY : lcwd_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // per-item outputs: history write, byte source and status
    always_comb
    begin
        item_wr   = 1'b0;
        item_copy = 1'b0;
        item_data = '0;
        item_err  = lcwd_pkg::ERR_NONE;
        if (fin_reg)
        begin
            item_err = lcwd_pkg::ERR_CMD;
        end
        else if (s_tuser == lcwd_pkg::CMD_STEP)
        begin
            if (!busy)
            begin
                item_err = lcwd_pkg::ERR_CMD;
            end
            else if (full)
            begin
                item_err = lcwd_pkg::ERR_FULL;
            end
            else if (copy_bad)
            begin
                item_err = lcwd_pkg::ERR_REF;
            end
            else
            begin
                item_wr   = 1'b1;
                item_copy = phase_reg == lcwd_pkg::PH_COPY;
                item_data = fill_reg;
            end
        end
        else
        begin
            case (phase_reg)
                lcwd_pkg::PH_LIT:
                begin
                    if (full)
                    begin
                        item_err = lcwd_pkg::ERR_FULL;
                    end
                    else
                    begin
                        item_wr   = 1'b1;
                        item_data = s_tdata;
                    end
                end
                lcwd_pkg::PH_ARG1:
                begin
                    if (!op_reg[7] && dist_bad)
                    begin
                        item_err = lcwd_pkg::ERR_REF;
                    end
                end
                lcwd_pkg::PH_COPY, lcwd_pkg::PH_FILL:
                begin
                    item_err = lcwd_pkg::ERR_CMD;
                end
                default:
                begin
                    item_err = lcwd_pkg::ERR_NONE;
                end
            endcase
        end
    end

    // history memory: read at the copy pointer, write from the read stage
    lcwd_ram #(
        .WIDTH(8),
        .DEPTH(OUT_SIZE)
    ) u_history (
        .clk  (clk),
        .we   (s1_adv && s1_reg.wr),
        .waddr(s1_reg.pos[ADDR_W-1:0]),
        .wdata(s1_wdata),
        .re   (accept),
        .raddr(cp_reg[ADDR_W-1:0]),
        .rdata(ram_q)
    );

    // byte written by the read stage, with forwarding for overlapped copies
    assign s1_wdata = s1_reg.is_copy ? (s1_reg.fwd ? s1_reg.fwd_data : ram_q) : s1_reg.data;

    // stage word for the accepted item
    always_comb
    begin
        s1_next.wr       = item_wr;
        s1_next.is_copy  = item_copy;
        s1_next.data     = item_data;
        s1_next.pos      = wp_reg[15:0];
        s1_next.want     = !fin_next && phase_next != lcwd_pkg::PH_COPY
                           && phase_next != lcwd_pkg::PH_FILL;
        s1_next.done     = fin_next;
        s1_next.total    = wp_next;
        s1_next.err      = item_err;
        s1_next.fwd      = item_copy && s1_adv && s1_reg.wr && s1_reg.pos == cp_reg;
        s1_next.fwd_data = s1_wdata;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcwd_pkg::PH_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            cp_reg        <= '0;
            fill_reg      <= '0;
            op_reg        <= '0;
            fin_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            cp_reg    <= cp_next;
            fill_reg  <= fill_next;
            op_reg    <= op_next;
            fin_reg   <= fin_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_flag_reg  <= s1_reg.wr;
            out_byte_reg  <= s1_reg.wr ? s1_wdata : 8'd0;
            out_pos_reg   <= s1_reg.wr ? s1_reg.pos : 16'd0;
            out_want_reg  <= s1_reg.want;
            out_done_reg  <= s1_reg.done;
            out_total_reg <= s1_reg.total;
            out_err_reg   <= s1_reg.err;
        end
    end

    // result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tdata  = {3'd0, out_err_reg, out_total_reg, out_done_reg, out_want_reg,
                       out_pos_reg, out_byte_reg};

    // an accepted word always lands in the read stage
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word not held in read stage");

    // no history write beyond the output buffer
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_wr |-> wp_reg < OUT_LIMIT)
        else $error("history write beyond output size");

    // forwarding only for copy bytes
    a_fwd_copy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.fwd |-> s1_reg.is_copy && s1_reg.wr)
        else $error("forward flag on a non-copy word");

    // end marker is sticky
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |=> fin_reg && wp_reg == $past(wp_reg))
        else $error("state changed after end marker");

    // a copy source is always behind the write pointer when the byte is written
    a_copy_source: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_copy |-> {1'b0, cp_reg} < wp_reg)
        else $error("copy reads an unwritten position");

endmodule

`default_nettype wire

@@ dv/lcw_decode_checker.sv @@
// ----------------------------------------------------------------------------
// lcw_decode_checker: result checker for the LCW stream decompressor
// Watches both stream channels. Each accepted input word is run through a
// local decoder model that keeps its own history and parser state. The
// expected result word is queued, and each accepted output word is compared
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module lcw_decode_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic        s_tuser,   // command
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // out_byte, out_position, want_byte, done_res,
                                        // total_length, error_code, pad
    input  wire logic        m_tuser,   // out_valid
    output int               mismatch_count,
    output int               words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_SIZE = 65536;
    localparam logic [7:0] CLASS_BIT = 8'h40;
    localparam logic [7:0] DIST_HI   = 8'h0F;

    // one result word as the block reports it
    typedef struct packed {
        logic           wr;
        logic [7:0]     data;
        logic [15:0]    pos;
        logic           want;
        logic           done;
        logic [16:0]    total;
        lcwd_pkg::err_t err;
    } out_word_t;

    // decoder model state
    logic [7:0]       history_mem [HIST_SIZE];
    logic [16:0]      wr_ptr;
    lcwd_pkg::phase_t phase;
    logic [7:0]       op_hold;
    logic [15:0]      left_cnt;
    logic [15:0]      src_ptr;
    logic [7:0]       fill_byte;
    logic             ended;

    out_word_t   expected_words [$];

    // append one byte to the output history
    function automatic void write_history(inout out_word_t w, input logic [7:0] v);
        history_mem[wr_ptr[15:0]] = v;
        w.wr   = 1'b1;
        w.data = v;
        w.pos  = wr_ptr[15:0];
        wr_ptr = wr_ptr + 17'd1;
    endfunction

    // advance the model by one input word and build the expected result
    function automatic out_word_t decode_step(input logic cmd, input logic [7:0] b);
        out_word_t   w;
        logic [16:0] rel_dist;
        w = '0;
        if (ended)
        begin
            w.err = lcwd_pkg::ERR_CMD;
        end
        else if (cmd == lcwd_pkg::CMD_STEP)
        begin
            if (phase == lcwd_pkg::PH_COPY || phase == lcwd_pkg::PH_FILL)
            begin
                if (wr_ptr >= 17'(HIST_SIZE))
                begin
                    w.err    = lcwd_pkg::ERR_FULL;
                    left_cnt = '0;
                    phase    = lcwd_pkg::PH_IDLE;
                end
                else if (phase == lcwd_pkg::PH_COPY && {1'b0, src_ptr} >= wr_ptr)
                begin
                    w.err    = lcwd_pkg::ERR_REF;
                    left_cnt = '0;
                    phase    = lcwd_pkg::PH_IDLE;
                end
                else
                begin
                    if (phase == lcwd_pkg::PH_FILL)
                    begin
                        write_history(w, fill_byte);
                    end
                    else
                    begin
                        write_history(w, history_mem[src_ptr]);
                        src_ptr = src_ptr + 16'd1;
                    end
                    left_cnt = left_cnt - 16'd1;
                    if (left_cnt == '0)
                        phase = lcwd_pkg::PH_IDLE;
                end
            end
            else
            begin
                w.err = lcwd_pkg::ERR_CMD;
            end
        end
        else
        begin
            case (phase)
                lcwd_pkg::PH_IDLE:
                begin
                    op_hold = b;
                    // relative copy, literal or end, fill or long copy, short copy
                    if ((b & lcwd_pkg::OP_END) == '0)
                    begin
                        left_cnt = 16'(b[7:4]) + lcwd_pkg::MIN_COPY;
                        phase    = lcwd_pkg::PH_ARG1;
                    end
                    else if ((b & CLASS_BIT) == '0)
                    begin
                        if (b == lcwd_pkg::OP_END)
                        begin
                            ended = 1'b1;
                        end
                        else
                        begin
                            left_cnt = 16'(b & lcwd_pkg::MASK_CNT6);
                            phase    = lcwd_pkg::PH_LIT;
                        end
                    end
                    else if (b == lcwd_pkg::OP_FILL || b == lcwd_pkg::OP_LCOPY)
                    begin
                        left_cnt = '0;
                        phase    = lcwd_pkg::PH_ARG1;
                    end
                    else
                    begin
                        left_cnt = 16'(b & lcwd_pkg::MASK_CNT6) + lcwd_pkg::MIN_COPY;
                        phase    = lcwd_pkg::PH_ARG1;
                    end
                end
                lcwd_pkg::PH_LIT:
                begin
                    // a full output drops the byte but keeps the run framed
                    if (wr_ptr < 17'(HIST_SIZE))
                        write_history(w, b);
                    else
                        w.err = lcwd_pkg::ERR_FULL;
                    left_cnt = left_cnt - 16'd1;
                    if (left_cnt == '0)
                        phase = lcwd_pkg::PH_IDLE;
                end
                lcwd_pkg::PH_ARG1:
                begin
                    if ((op_hold & lcwd_pkg::OP_END) == '0)
                    begin
                        rel_dist = {1'b0, (op_hold & DIST_HI), b};
                        if (rel_dist > wr_ptr)
                        begin
                            w.err    = lcwd_pkg::ERR_REF;
                            left_cnt = '0;
                            phase    = lcwd_pkg::PH_IDLE;
                        end
                        else
                        begin
                            src_ptr = 16'(wr_ptr - rel_dist);
                            phase   = lcwd_pkg::PH_COPY;
                        end
                    end
                    else if (op_hold == lcwd_pkg::OP_FILL || op_hold == lcwd_pkg::OP_LCOPY)
                    begin
                        left_cnt = 16'(b);
                        phase    = lcwd_pkg::PH_CNT_HI;
                    end
                    else
                    begin
                        src_ptr = 16'(b);
                        phase   = lcwd_pkg::PH_POS_HI;
                    end
                end
                lcwd_pkg::PH_CNT_HI:
                begin
                    left_cnt = left_cnt | {b, 8'h00};
                    phase    = lcwd_pkg::PH_ARG3;
                end
                lcwd_pkg::PH_ARG3:
                begin
                    if (op_hold == lcwd_pkg::OP_FILL)
                    begin
                        fill_byte = b;
                        phase     = (left_cnt != '0) ? lcwd_pkg::PH_FILL : lcwd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        src_ptr = 16'(b);
                        phase   = lcwd_pkg::PH_POS_HI;
                    end
                end
                lcwd_pkg::PH_POS_HI:
                begin
                    src_ptr = src_ptr | {b, 8'h00};
                    phase   = (left_cnt != '0) ? lcwd_pkg::PH_COPY : lcwd_pkg::PH_IDLE;
                end
                default:
                begin
                    // byte offered while a copy or fill runs
                    w.err = lcwd_pkg::ERR_CMD;
                end
            endcase
        end
        w.want  = !ended && phase != lcwd_pkg::PH_COPY && phase != lcwd_pkg::PH_FILL;
        w.done  = ended;
        w.total = wr_ptr;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [16:0] exp_v,
                                        input logic [16:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // compare output words first, then queue the prediction for the input word
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t exp_w;
        if (!rst_n)
        begin
            wr_ptr         = '0;
            phase          = lcwd_pkg::PH_IDLE;
            op_hold        = '0;
            left_cnt       = '0;
            src_ptr        = '0;
            fill_byte      = '0;
            ended          = 1'b0;
            mismatch_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no expected word pending");
                    mismatch_count++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    check_field("out_valid",    17'(exp_w.wr),    17'(m_tuser));
                    check_field("out_byte",     17'(exp_w.data),  17'(m_tdata[7:0]));
                    check_field("out_position", 17'(exp_w.pos),   17'(m_tdata[23:8]));
                    check_field("want_byte",    17'(exp_w.want),  17'(m_tdata[24]));
                    check_field("done_res",     17'(exp_w.done),  17'(m_tdata[25]));
                    check_field("total_length", exp_w.total,      m_tdata[42:26]);
                    check_field("error_code",   17'(exp_w.err),   17'(m_tdata[44:43]));
                end
            end
            if (s_tvalid && s_tready)
                expected_words.push_back(decode_step(s_tuser, s_tdata));
        end
        words_pending = expected_words.size();
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the LCW stream decompressor
// Drives compressed bytes and step requests: a directed opening over the
// special cases, a random run of mostly well formed commands with stray words mixed
// in, and a final stretch without idling that ends the stream. Both channels
// idle at random; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT        = 1000000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam logic [7:0] SHORT_COPY_BASE = 8'hC0;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;
    logic        m_tuser;

    int mismatch_count;
    int words_pending;
    int words_sent  = 0;
    int out_written = 0;    // output bytes the command plan has produced
    bit tx_gaps     = 1'b0;
    bit rx_stalls   = 1'b0;
    bit long_hold   = 1'b0;
    bit hold_done   = 1'b0;

    lz_copy_fill_decompressor_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lcw_decode_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("FAIL lz_copy_fill_decompressor_unit");
        $finish;
    end

    // receiver side: random stalls and one long hold-off
    initial
    begin : rx_side
        int n;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // offer one word, with an optional gap before it
    task automatic send_word(input logic cmd, input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // step requests; the first n_live of them find a copy or fill running
    task automatic send_steps(input int n_steps, input int n_live);
        for (int i = 0; i < n_steps; i++)
        begin
            // stray byte during a running copy or fill, dropped by the block
            if (i < n_live && $urandom_range(0, 19) == 0)
                send_word(lcwd_pkg::CMD_DATA, 8'($urandom));
            send_word(lcwd_pkg::CMD_STEP, 8'($urandom));
        end
    endtask

    function automatic int extra_steps();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
    endfunction

    // literal opcodes share the top bit with the end marker
    task automatic lit_run(input int n);
        send_word(lcwd_pkg::CMD_DATA, lcwd_pkg::OP_END | 8'(n));
        repeat (n) send_word(lcwd_pkg::CMD_DATA, 8'($urandom));
        out_written += n;
    endtask

    task automatic rel_copy(input logic [2:0] code, input logic [11:0] rel_dist,
                            input int extra);
        int n;
        n = int'(code) + 3;
        send_word(lcwd_pkg::CMD_DATA, {1'b0, code, rel_dist[11:8]});
        send_word(lcwd_pkg::CMD_DATA, rel_dist[7:0]);
        if (rel_dist == '0 || int'(rel_dist) > out_written)
        begin
            send_steps(1 + extra, 0);
        end
        else
        begin
            send_steps(n + extra, n);
            out_written += n;
        end
    endtask

    task automatic fill_run(input logic [15:0] cnt, input logic [7:0] val, input int extra);
        send_word(lcwd_pkg::CMD_DATA, lcwd_pkg::OP_FILL);
        send_word(lcwd_pkg::CMD_DATA, cnt[7:0]);
        send_word(lcwd_pkg::CMD_DATA, cnt[15:8]);
        send_word(lcwd_pkg::CMD_DATA, val);
        send_steps(int'(cnt) + extra, int'(cnt));
        out_written += int'(cnt);
    endtask

    // long form takes a 16-bit count, short form 3 to 64 in the opcode
    task automatic abs_copy(input bit long_form, input logic [15:0] cnt,
                            input logic [15:0] pos, input int extra);
        bit src_ok;
        src_ok = int'(pos) < out_written && cnt != '0;
        if (long_form)
        begin
            send_word(lcwd_pkg::CMD_DATA, lcwd_pkg::OP_LCOPY);
            send_word(lcwd_pkg::CMD_DATA, cnt[7:0]);
            send_word(lcwd_pkg::CMD_DATA, cnt[15:8]);
        end
        else
        begin
            send_word(lcwd_pkg::CMD_DATA, SHORT_COPY_BASE + (cnt[7:0] - 8'd3));
        end
        send_word(lcwd_pkg::CMD_DATA, pos[7:0]);
        send_word(lcwd_pkg::CMD_DATA, pos[15:8]);
        if (src_ok)
        begin
            send_steps(int'(cnt) + extra, int'(cnt));
            out_written += int'(cnt);
        end
        else
        begin
            send_steps(1 + extra, 0);
        end
    endtask

    // one random command, mostly well formed with small sizes
    task automatic random_command();
        int          kind;
        int          lim;
        logic [15:0] cnt;
        logic [15:0] pos;
        if ($urandom_range(0, 15) == 0)
            tx_gaps = !tx_gaps;
        if ($urandom_range(0, 15) == 0)
            rx_stalls = !rx_stalls;
        kind = $urandom_range(0, 99);
        lim  = (out_written > 4095) ? 4095 : out_written;
        pos  = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                           : 16'($urandom_range(0, out_written - 1));
        if (kind < 22)
        begin
            lit_run(($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8));
        end
        else if (kind < 48)
        begin
            rel_copy(3'($urandom),
                     ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(1, lim)),
                     extra_steps());
        end
        else if (kind < 63)
        begin
            case ($urandom_range(0, 29))
                0:       cnt = '0;
                1:       cnt = 16'($urandom_range(256, 600));
                default: cnt = 16'($urandom_range(1, 20));
            endcase
            fill_run(cnt, 8'($urandom), extra_steps());
        end
        else if (kind < 75)
        begin
            cnt = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
            abs_copy(1'b1, cnt, pos, extra_steps());
        end
        else if (kind < 90)
        begin
            cnt = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(3, 64))
                                              : 16'($urandom_range(3, 10));
            abs_copy(1'b0, cnt, pos, extra_steps());
        end
        else
        begin
            // requests with nothing to copy
            send_steps($urandom_range(1, 3), 0);
        end
    endtask

    initial
    begin : stimulus
        int target;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;

        // request before any command
        send_word(lcwd_pkg::CMD_STEP, 8'hFF);
        // literal run holding the byte extremes
        send_word(lcwd_pkg::CMD_DATA, 8'h83);
        send_word(lcwd_pkg::CMD_DATA, 8'h00);
        send_word(lcwd_pkg::CMD_DATA, 8'hFF);
        send_word(lcwd_pkg::CMD_DATA, 8'h80);
        out_written = 3;
        // overlapping copy at distance one, with a byte offered mid-copy
        send_word(lcwd_pkg::CMD_DATA, 8'h00);
        send_word(lcwd_pkg::CMD_DATA, 8'h01);
        send_word(lcwd_pkg::CMD_STEP, 8'h00);
        send_word(lcwd_pkg::CMD_DATA, 8'h7F);
        send_word(lcwd_pkg::CMD_STEP, 8'h00);
        send_word(lcwd_pkg::CMD_STEP, 8'h00);
        out_written = 6;
        // distance zero fails on the request, then a request while idle
        send_word(lcwd_pkg::CMD_DATA, 8'h00);
        send_word(lcwd_pkg::CMD_DATA, 8'h00);
        send_word(lcwd_pkg::CMD_STEP, 8'h00);
        send_word(lcwd_pkg::CMD_STEP, 8'h00);
        // distance reaching before the start of the output
        send_word(lcwd_pkg::CMD_DATA, 8'h0F);
        send_word(lcwd_pkg::CMD_DATA, 8'hFF);
        // zero-count fill and long copy, then a one-byte fill
        fill_run(16'h0000, 8'h55, 0);
        abs_copy(1'b1, 16'h0000, 16'h0000, 0);
        fill_run(16'h0001, 8'hA5, 0);
        // short copy from a position not yet written
        abs_copy(1'b0, 16'd3, 16'hFFFF, 0);

        // drain before the random part
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);

        target = words_sent + RANDOM_ITEMS;
        while (words_sent < target)
        begin
            if (!hold_done && words_sent > target - RANDOM_ITEMS / 2)
            begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            random_command();
        end

        // last part runs without idling: fill, literals, a request while idle and the end of stream
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        fill_run(16'd32, 8'($urandom), 0);
        lit_run(3);
        send_word(lcwd_pkg::CMD_STEP, 8'h00);
        // end marker, then words after the end
        send_word(lcwd_pkg::CMD_DATA, lcwd_pkg::OP_END);
        send_word(lcwd_pkg::CMD_STEP, 8'h00);
        send_word(lcwd_pkg::CMD_DATA, 8'h00);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("PASS lz_copy_fill_decompressor_unit");
        else
            $display("FAIL lz_copy_fill_decompressor_unit");
        $finish;
    end

endmodule
